@@ rtl/lfa_pkg.sv @@
// ----------------------------------------------------------------------------
// lfa_pkg: shared types and constants for the layout force accumulator
// Opcodes, register indexes, fixed field widths and the sequencer states.
// ----------------------------------------------------------------------------
package lfa_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ACC_WIDTH_DEF   = 48;

  localparam int CFG_W      = 32;  // factor registers, Q16.16
  localparam int LEN_W      = 23;  // length registers, Q15.8
  localparam int CFG_IDX_W  = 3;
  localparam int OPCODE_W   = 2;
  localparam int MUL_CHUNK  = 32;  // operand slice of the shared multiplier
  localparam int REPEL_SHIFT  = 16;
  localparam int SPRING_SHIFT = 8;

  localparam logic [LEN_W-1:0] MIN_DIST_RST = LEN_W'(2560);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPULSION  = 3'd0,
    REG_FAKE_REP   = 3'd1,
    REG_SPRING     = 3'd2,
    REG_SPRING_LEN = 3'd3,
    REG_MIN_DIST   = 3'd4
  } cfg_reg_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_REPEL    = 2'd0,
    OP_SPRING   = 2'd1,
    OP_FAKE_PT  = 2'd2,
    OP_FAKE_MID = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_CLAMP,
    ST_D2,
    ST_D3,
    ST_NUM1,
    ST_NUM2,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } lfa_state_e;

endpackage

@@ rtl/lfa_div.sv @@
// ----------------------------------------------------------------------------
// lfa_div: restoring divider, one quotient bit per cycle
// Flags overflow up front when the quotient does not fit QUO_W bits.
// ----------------------------------------------------------------------------
module lfa_div #(
  parameter int NUM_W = 82,
  parameter int DEN_W = 75,
  parameter int QUO_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic             ovf_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] low_q;
  logic [QUO_W-1:0] quo_q;

  logic [NUM_W-1:0] num_hi;
  logic             hi_big;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign num_hi = num_i >> QUO_W;
  assign hi_big = num_hi >= NUM_W'(den_i);
  assign rem_sh = {rem_q, low_q[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ovf_q <= hi_big;
        if (hi_big) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(QUO_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DEN_W'(num_hi);
      low_q <= num_i[QUO_W-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/layout_force_accumulator.sv @@
// ----------------------------------------------------------------------------
// layout_force_accumulator: force on one layout node from interaction beats
// Each slave beat carries an opcode and coordinates; the force term is
// summed with saturation, and on the beat marked tlast the sums go out on
// the master side and are cleared.
// Channels: s_axis (interaction beats, tlast ends a node), m_axis (force
// sums, tuser = saturation flag), cfg (register writes; the user is to
// write only in the idle state, which the block itself does not enforce).
// One beat at a time: tready is high only in the idle state. A beat first
// finds the distance (squares, square root, clamp, then d^2 and d^3), then
// per axis forms the force numerator on the shared multiplier (two products
// for a spring), divides and adds; a tlast beat then emits the sums.
// The restoring divider works out one quotient bit per cycle.
// The result sits in an output register; the next beat is taken while it
// waits. A tlast beat that finds the output register still full holds
// until the receiver takes the previous result.
// Reset clears the sums, the flag and the registers to their defaults.
// ----------------------------------------------------------------------------
module layout_force_accumulator
  import lfa_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
  localparam int IN_W  = ((OPCODE_W + 6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * ACC_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // opcode, near_x, near_y, far_x, far_y, alt_x, alt_y
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // force_x, force_y
  output logic [OUT_W-1:0]     m_axis_tdata,
  // saturated
  output logic                 m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW + 1;
  localparam int DW   = (MW > LEN_W) ? MW : LEN_W;
  localparam int SW   = 2 * MW;
  localparam int RW   = MW + 1;
  localparam int PW0  = (CFG_W + MW + REPEL_SHIFT > CFG_W + DW + MW) ?
                        CFG_W + MW + REPEL_SHIFT : CFG_W + DW + MW;
  localparam int PW1  = (PW0 > 3 * DW) ? PW0 : 3 * DW;
  localparam int PW   = (PW1 > ACC_WIDTH) ? PW1 : ACC_WIDTH;
  localparam int VW   = 3 * DW;
  localparam int NCH  = (PW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AW   = NCH * MUL_CHUNK;
  localparam int IDX_W = $clog2(NCH);
  localparam int SCW  = $clog2(MW + 1);

  localparam logic signed [ACC_WIDTH+1:0] ACC_MAX = {3'b000, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH+1:0] ACC_MIN = {3'b111, {(ACC_WIDTH-1){1'b0}}};

  // configuration
  logic [CFG_W-1:0] rep_q, fake_rep_q, spring_q;
  logic [LEN_W-1:0] spring_len_q, min_dist_q;

  // sequencer and datapath
  lfa_state_e        state_q, state_d;
  opcode_e           op_q;
  logic              last_q;
  logic [MW-1:0]     adx_q, ady_q;
  logic              negx_q, negy_q;
  logic              axis_q, axis_d;
  logic [SCW-1:0]    step_q, step_d;
  logic [AW-1:0]     mul_a_q, mul_a_d;
  logic [DW-1:0]     mul_b_q, mul_b_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [SW-1:0]     rad_q, rad_d;
  logic [MW-1:0]     root_q, root_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     dist_q, dist_d;
  logic [VW-1:0]     d3_q, d3_d;
  logic signed [ACC_WIDTH-1:0] sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic              clip_q, clip_d;
  logic              m_valid_q, m_valid_d;
  logic [ACC_WIDTH-1:0] out_x_q, out_y_q;
  logic              out_sat_q;
  logic              emit;

  // input unpack
  logic [OPCODE_W-1:0]   in_op;
  logic signed [CW-1:0]  in_nx, in_ny, in_fx, in_fy, in_ax, in_ay;
  logic signed [CW:0]    mid_x, mid_y;
  logic signed [CW-1:0]  far_x, far_y;
  logic signed [CW:0]    dx, dy;
  logic                  in_fire;

  assign in_op = s_axis_tdata[OPCODE_W-1:0];
  assign in_nx = s_axis_tdata[OPCODE_W +: CW];
  assign in_ny = s_axis_tdata[OPCODE_W + CW +: CW];
  assign in_fx = s_axis_tdata[OPCODE_W + 2*CW +: CW];
  assign in_fy = s_axis_tdata[OPCODE_W + 3*CW +: CW];
  assign in_ax = s_axis_tdata[OPCODE_W + 4*CW +: CW];
  assign in_ay = s_axis_tdata[OPCODE_W + 5*CW +: CW];

  assign mid_x = (CW+1)'(in_fx) + (CW+1)'(in_ax);
  assign mid_y = (CW+1)'(in_fy) + (CW+1)'(in_ay);
  assign far_x = (in_op == OP_FAKE_MID) ? mid_x[CW:1] : in_fx;
  assign far_y = (in_op == OP_FAKE_MID) ? mid_y[CW:1] : in_fy;
  assign dx    = (CW+1)'(in_nx) - (CW+1)'(far_x);
  assign dy    = (CW+1)'(in_ny) - (CW+1)'(far_y);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // shared multiplier: one 32-bit slice of mul_a per cycle
  logic [MUL_CHUNK-1:0]    mul_slice;
  logic [MUL_CHUNK+DW-1:0] mul_part;
  logic [PW-1:0]           prod_sum;
  logic                    mul_last;

  assign mul_slice = mul_a_q[step_q[IDX_W-1:0] * MUL_CHUNK +: MUL_CHUNK];
  assign mul_part  = (MUL_CHUNK+DW)'(mul_slice) * (MUL_CHUNK+DW)'(mul_b_q);
  assign prod_sum  = prod_q + (PW'(mul_part) << (MUL_CHUNK * step_q[IDX_W-1:0]));
  assign mul_last  = (step_q == SCW'(NCH - 1));

  // square root digit step
  logic [RW+1:0] sq_sh, sq_trial;
  logic          sq_ge;

  assign sq_sh    = {rem_q, rad_q[SW-1 -: 2]};
  assign sq_trial = {{(RW-MW){1'b0}}, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // distance and term selection
  logic [DW-1:0]    min_d, root_ext, stretch, cur_ad, setup_ad;
  logic             is_spring, longer, cur_neg, term_neg;
  logic [CFG_W-1:0] rep_k;

  assign min_d    = (min_dist_q == '0) ? DW'(1) : DW'(min_dist_q);
  assign root_ext = DW'(root_q);
  assign is_spring = (op_q == OP_SPRING);
  assign longer   = dist_q >= DW'(spring_len_q);
  assign stretch  = longer ? dist_q - DW'(spring_len_q) : DW'(spring_len_q) - dist_q;
  assign cur_ad   = axis_q ? DW'(ady_q) : DW'(adx_q);
  assign setup_ad = (state_q == ST_ACC) ? DW'(ady_q) : DW'(adx_q);
  assign cur_neg  = axis_q ? negy_q : negx_q;
  assign term_neg = is_spring ? (longer != cur_neg) : cur_neg;
  assign rep_k    = (op_q == OP_REPEL) ? rep_q : fake_rep_q;

  // divider
  logic                 div_start, div_done, div_ovf;
  logic [PW-1:0]        div_num;
  logic [VW-1:0]        div_den;
  logic [ACC_WIDTH-1:0] div_quo;

  assign div_num = (state_q == ST_NUM2) ? prod_sum : prod_sum << REPEL_SHIFT;
  assign div_den = is_spring ? VW'({dist_q, {SPRING_SHIFT{1'b0}}}) : d3_q;

  lfa_div #(
    .NUM_W (PW),
    .DEN_W (VW),
    .QUO_W (ACC_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  // saturating add
  logic signed [ACC_WIDTH-1:0] cur_sum, new_sum;
  logic signed [ACC_WIDTH+1:0] s_ext, q_ext, res;
  logic                        clip_now;

  assign cur_sum  = axis_q ? sum_y_q : sum_x_q;
  assign s_ext    = (ACC_WIDTH+2)'(cur_sum);
  assign q_ext    = {2'b00, div_quo};
  assign res      = term_neg ? s_ext - q_ext : s_ext + q_ext;
  assign clip_now = div_ovf || (res > ACC_MAX) || (res < ACC_MIN);
  assign new_sum  = !clip_now ? res[ACC_WIDTH-1:0] :
                    term_neg ? ACC_MIN[ACC_WIDTH-1:0] : ACC_MAX[ACC_WIDTH-1:0];

  assign emit = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    step_d    = step_q;
    mul_a_d   = mul_a_q;
    mul_b_d   = mul_b_q;
    prod_d    = prod_q;
    rad_d     = rad_q;
    root_d    = root_q;
    rem_d     = rem_q;
    dist_d    = dist_q;
    d3_d      = d3_q;
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    clip_d    = clip_q;
    div_start = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready;
    unique case (state_q) inside
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SQ_X;
          step_d  = '0;
          prod_d  = '0;
          axis_d  = 1'b0;
          mul_a_d = AW'(dx < 0 ? -dx : dx);
          mul_b_d = DW'(dx < 0 ? -dx : dx);
        end
      end
      ST_SQ_X, ST_SQ_Y, ST_D2, ST_D3, ST_NUM1, ST_NUM2: begin
        prod_d = prod_sum;
        step_d = step_q + SCW'(1);
        if (mul_last) begin
          step_d = '0;
          prod_d = '0;
          unique case (state_q)
            ST_SQ_X: begin
              prod_d  = prod_sum;
              mul_a_d = AW'(ady_q);
              mul_b_d = DW'(ady_q);
              state_d = ST_SQ_Y;
            end
            ST_SQ_Y: begin
              rad_d   = prod_sum[SW-1:0];
              root_d  = '0;
              rem_d   = '0;
              state_d = ST_SQRT;
            end
            ST_D2: begin
              mul_a_d = AW'(prod_sum);
              mul_b_d = dist_q;
              state_d = ST_D3;
            end
            ST_D3: begin
              d3_d    = VW'(prod_sum);
              mul_a_d = is_spring ? AW'(spring_q) : AW'(rep_k);
              mul_b_d = is_spring ? stretch : setup_ad;
              state_d = ST_NUM1;
            end
            ST_NUM1: begin
              if (is_spring) begin
                mul_a_d = AW'(prod_sum);
                mul_b_d = cur_ad;
                state_d = ST_NUM2;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          endcase
        end
      end
      ST_SQRT: begin
        rem_d  = sq_ge ? RW'(sq_sh - sq_trial) : RW'(sq_sh);
        root_d = {root_q[MW-2:0], sq_ge};
        rad_d  = {rad_q[SW-3:0], 2'b00};
        step_d = step_q + SCW'(1);
        if (step_q == SCW'(MW - 1)) begin
          step_d  = '0;
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        dist_d  = (root_ext < min_d) ? min_d : root_ext;
        mul_a_d = AW'(dist_d);
        mul_b_d = dist_d;
        prod_d  = '0;
        state_d = ST_D2;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (axis_q) begin
          sum_y_d = new_sum;
        end else begin
          sum_x_d = new_sum;
        end
        clip_d = clip_q || clip_now;
        if (!axis_q) begin
          axis_d  = 1'b1;
          mul_a_d = is_spring ? AW'(spring_q) : AW'(rep_k);
          mul_b_d = is_spring ? stretch : setup_ad;
          prod_d  = '0;
          step_d  = '0;
          state_d = ST_NUM1;
        end else begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          m_valid_d = 1'b1;
          sum_x_d   = '0;
          sum_y_d   = '0;
          clip_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      axis_q       <= 1'b0;
      step_q       <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      clip_q       <= 1'b0;
      m_valid_q    <= 1'b0;
      rep_q        <= '0;
      fake_rep_q   <= '0;
      spring_q     <= '0;
      spring_len_q <= '0;
      min_dist_q   <= MIN_DIST_RST;
    end else begin
      state_q   <= state_d;
      axis_q    <= axis_d;
      step_q    <= step_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      clip_q    <= clip_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REPULSION:  rep_q        <= cfg_wdata_i;
          REG_FAKE_REP:   fake_rep_q   <= cfg_wdata_i;
          REG_SPRING:     spring_q     <= cfg_wdata_i;
          REG_SPRING_LEN: spring_len_q <= cfg_wdata_i[LEN_W-1:0];
          REG_MIN_DIST:   min_dist_q   <= cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= prod_d;
    rad_q   <= rad_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    dist_q  <= dist_d;
    d3_q    <= d3_d;
    if (in_fire) begin
      op_q   <= opcode_e'(in_op);
      last_q <= s_axis_tlast;
      adx_q  <= MW'(dx < 0 ? -dx : dx);
      ady_q  <= MW'(dy < 0 ? -dy : dy);
      negx_q <= dx < 0;
      negy_q <= dy < 0;
    end
    if (emit) begin
      out_x_q   <= sum_x_q;
      out_y_q   <= sum_y_q;
      out_sat_q <= clip_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({out_y_q, out_x_q});
  assign m_axis_tuser  = out_sat_q;

  a_clear_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (sum_x_q == '0) && (sum_y_q == '0) && !clip_q)
    else $error("sums not cleared after emit");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result raised without an emit");

endmodule
